>>> sv/hts_pkg.sv
// Package with byte codes, entity names and result-building helpers for the text stripper.
package hts_pkg;

  // Byte codes with special meaning in the text stream.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_MID0  = 8'hC2;
  localparam logic [7:0] CH_MID1  = 8'hB7;

  // Entity names that are recognized, first character in the top byte.
  localparam logic [31:0] ENT_QUOT   = "quot";
  localparam logic [47:0] ENT_MIDDOT = "middot";
  localparam logic [23:0] ENT_AMP    = "amp";
  localparam logic [15:0] ENT_LT     = "lt";
  localparam logic [15:0] ENT_GT     = "gt";

  // Result slots per input item and the width of a slot count.
  localparam int unsigned MAX_RES = 4;
  localparam int unsigned RES_W   = 3;

  // Period run state.
  typedef enum logic [1:0] {
    PC_NONE   = 2'd0,
    PC_HELD   = 2'd1,
    PC_CANCEL = 2'd2
  } period_e;

  // Results of one item under construction plus the state that emitting touches.
  typedef struct packed {
    logic                      emit;
    logic                      lws;
    period_e                   pc;
    logic [RES_W-1:0]          n;
    logic [MAX_RES-1:0][7:0]   b;
    logic [MAX_RES-1:0]        e;
  } ctx_t;

  // Append one text byte to the result list.
  function automatic ctx_t put_byte(ctx_t c, logic [7:0] x);
    ctx_t r;
    r = c;
    if (r.n < RES_W'(MAX_RES)) begin
      r.b[r.n[1:0]] = x;
      r.e[r.n[1:0]] = 1'b0;
      r.n           = r.n + RES_W'(1);
    end
    r.emit = 1'b1;
    r.lws  = (x == CH_SPACE);
    return r;
  endfunction

  // Append the end-of-text marker.
  function automatic ctx_t put_end(ctx_t c);
    ctx_t r;
    r = c;
    if (r.n < RES_W'(MAX_RES)) begin
      r.b[r.n[1:0]] = CH_NUL;
      r.e[r.n[1:0]] = 1'b1;
      r.n           = r.n + RES_W'(1);
    end
    return r;
  endfunction

  // Emit a held period, then clear the period run.
  function automatic ctx_t release_period(ctx_t c);
    ctx_t r;
    r = c;
    if (r.pc == PC_HELD) begin
      r = put_byte(r, CH_DOT);
    end
    r.pc = PC_NONE;
    return r;
  endfunction

endpackage

>>> sv/html_text_stripper_top.sv
// Top level of the text stripper: byte classification, entity capture and result buffer.

// The block takes one text byte per transfer and produces zero to three result
// transfers for it. All work for a byte is done in the cycle of its input
// transfer, and the results land in a small result register bank that drains
// one result per cycle on the output channel while out_ready_i is high. The
// next byte can be taken in the same cycle as the final result of the
// previous byte leaves, so the single output channel sets the rate. The
// entity name store needs no clearing after reset: only entries written
// for the current name are ever compared.
module html_text_stripper_top
  import hts_pkg::*;
#(
  parameter int unsigned NAME_BYTES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       is_end_o
);

  localparam int unsigned LEN_W = $clog2(NAME_BYTES + 2);
  localparam int unsigned IDX_W = $clog2(NAME_BYTES);

  // Stream state.
  logic             tag_q, tag_d;
  logic             sp_q, sp_d;
  period_e          pc_q;
  logic             ent_q, ent_d;
  logic [LEN_W-1:0] nlen_q, nlen_d;
  logic             emit_q, lws_q;
  logic             ended_q, ended_d;

  // Entity name store, no reset.
  logic [7:0]       name_q [NAME_BYTES];
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;

  // Result buffer.
  logic [MAX_RES-1:0][7:0] res_b_q;
  logic [MAX_RES-1:0]      res_e_q;
  logic [RES_W-1:0]        cnt_q;
  logic [RES_W-1:0]        rd_q;

  logic in_xfer, out_xfer, cap;
  ctx_t c;

  assign in_xfer  = in_valid_i & in_ready_o;
  assign out_xfer = out_valid_o & out_ready_i;

  // Per-byte processing: results and next state.
  always_comb begin
    c      = '0;
    c.emit = emit_q;
    c.lws  = lws_q;
    c.pc   = pc_q;
    tag_d   = tag_q;
    sp_d    = sp_q;
    ent_d   = ent_q;
    nlen_d  = nlen_q;
    ended_d = ended_q;
    cap     = 1'b0;
    wr_en   = 1'b0;
    wr_idx  = nlen_q[IDX_W-1:0];

    if (!ended_q) begin
      if (in_byte_i == CH_NUL) begin
        ended_d = 1'b1;
      end else if (in_byte_i == CH_LT || in_byte_i == CH_GT || tag_q) begin
        cap = ent_q;
        if (in_byte_i == CH_LT) begin
          tag_d = 1'b1;
        end else if (in_byte_i == CH_GT) begin
          tag_d = 1'b0;
        end
      end else begin
        case (in_byte_i)
          CH_AMP: begin
            sp_d   = 1'b0;
            c      = release_period(c);
            ent_d  = 1'b1;
            nlen_d = '0;
          end
          CH_SEMI: begin
            if (!sp_q && c.pc == PC_NONE) begin
              if (ent_q) begin
                ent_d = 1'b0;
                // Named entity lookup; empty and overlong names give nothing.
                if (nlen_q == LEN_W'(4) &&
                    {name_q[0], name_q[1], name_q[2], name_q[3]} == ENT_QUOT) begin
                  c = put_byte(c, CH_QUOTE);
                end else if (nlen_q == LEN_W'(6) &&
                             {name_q[0], name_q[1], name_q[2], name_q[3], name_q[4],
                              name_q[5]} == ENT_MIDDOT) begin
                  c = put_byte(c, CH_MID0);
                  c = put_byte(c, CH_MID1);
                end else if (nlen_q == LEN_W'(3) &&
                             {name_q[0], name_q[1], name_q[2]} == ENT_AMP) begin
                  c = put_byte(c, CH_AMP);
                end else if (nlen_q == LEN_W'(2) && {name_q[0], name_q[1]} == ENT_LT) begin
                  c = put_byte(c, CH_LT);
                end else if (nlen_q == LEN_W'(2) && {name_q[0], name_q[1]} == ENT_GT) begin
                  c = put_byte(c, CH_GT);
                end
              end else begin
                c = put_byte(c, CH_SEMI);
              end
            end else if (sp_q) begin
              c    = put_byte(c, CH_SEMI);
              sp_d = 1'b0;
            end else begin
              c = release_period(c);
              c = put_byte(c, CH_SEMI);
            end
          end
          CH_SPACE: begin
            if (!sp_q) begin
              sp_d = 1'b1;
              c    = release_period(c);
              if (c.emit && !c.lws) begin
                c = put_byte(c, CH_SPACE);
              end
            end
            c     = release_period(c);
            ent_d = 1'b0;
          end
          CH_DOT: begin
            cap = ent_q;
            if (c.pc == PC_HELD && !sp_q && !ent_q) begin
              c.pc = PC_CANCEL;
            end else if (c.pc == PC_NONE && !sp_q && !ent_q) begin
              c.pc = PC_HELD;
            end else if (c.pc == PC_HELD && sp_q) begin
              c.pc = PC_CANCEL;
              sp_d = 1'b0;
            end else if (c.pc == PC_NONE && sp_q) begin
              c.pc = PC_HELD;
              sp_d = 1'b0;
            end
          end
          default: begin
            sp_d = 1'b0;
            c    = release_period(c);
            if (ent_q) begin
              cap = 1'b1;
            end else begin
              c = put_byte(c, in_byte_i);
            end
          end
        endcase
      end
    end

    // Name capture, saturating one past the store size.
    if (cap) begin
      wr_en = (nlen_q < LEN_W'(NAME_BYTES));
      if (nlen_q <= LEN_W'(NAME_BYTES)) begin
        nlen_d = nlen_q + LEN_W'(1);
      end
    end

    // Final byte: flush, terminate, and return to the reset state.
    if (last_i) begin
      c       = release_period(c);
      c       = put_end(c);
      c.emit  = 1'b0;
      c.lws   = 1'b0;
      tag_d   = 1'b0;
      sp_d    = 1'b0;
      ent_d   = 1'b0;
      nlen_d  = '0;
      ended_d = 1'b0;
    end
  end

  // Stream state registers, updated on each input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q   <= 1'b0;
      sp_q    <= 1'b0;
      pc_q    <= PC_NONE;
      ent_q   <= 1'b0;
      nlen_q  <= '0;
      emit_q  <= 1'b0;
      lws_q   <= 1'b0;
      ended_q <= 1'b0;
    end else if (in_xfer) begin
      tag_q   <= tag_d;
      sp_q    <= sp_d;
      pc_q    <= c.pc;
      ent_q   <= ent_d;
      nlen_q  <= nlen_d;
      emit_q  <= c.emit;
      lws_q   <= c.lws;
      ended_q <= ended_d;
    end
  end

  // Entity name store write port.
  always_ff @(posedge clk_i) begin
    if (in_xfer && wr_en) begin
      name_q[wr_idx] <= in_byte_i;
    end
  end

  // Result buffer control: load on input transfer, step on output transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (in_xfer) begin
      cnt_q <= c.n;
      rd_q  <= '0;
    end else if (out_xfer) begin
      rd_q <= rd_q + RES_W'(1);
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_b_q <= c.b;
      res_e_q <= c.e;
    end
  end

  // Take a new byte once the buffer is empty or its final result leaves now.
  assign in_ready_o  = (rd_q == cnt_q) || ((rd_q + RES_W'(1) == cnt_q) && out_ready_i);
  assign out_valid_o = (rd_q != cnt_q);
  assign out_byte_o  = res_b_q[rd_q[1:0]];
  assign is_end_o    = res_e_q[rd_q[1:0]];

  // No byte produces more than three results.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= RES_W'(3))
    else $error("result count exceeds three");

  // The read pointer never passes the fill count.
  assert property (@(posedge clk_i) disable iff (!rst_ni) rd_q <= cnt_q)
    else $error("result read pointer past fill count");

  // The end marker is always the final result of its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o && is_end_o |-> rd_q + RES_W'(1) == cnt_q)
    else $error("end marker is not the final result");

  // A final byte leaves the stream state cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   in_xfer && last_i |=> !ended_q && !emit_q && pc_q == PC_NONE && !tag_q)
    else $error("state not cleared after final byte");

endmodule
